// File: rtl/power_buffer_current_limiter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power buffer current limiter
// Implication checks clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef POWER_BUFFER_CURRENT_LIMITER_ASSERT_SVH
`define POWER_BUFFER_CURRENT_LIMITER_ASSERT_SVH

// Same-cycle implication.
`define PBCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PBCL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pbcl_pkg.sv
// ----------------------------------------------------------------------------
// pbcl_pkg
// Types, constants and helpers shared by the current limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pbcl_pkg;

	localparam int NCMD       = 4;
	localparam int MIDX_W     = 2;
	localparam int CMD_W      = 16;
	localparam int PWR_W      = 32;
	localparam int LVL_W      = 40;
	localparam int LIM_W      = 17;
	localparam int SUM_W      = 18;
	localparam int PROD_W     = 33;
	localparam int QSTEPS     = 16;
	localparam int STEP_W     = 4;
	localparam int E_W        = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam int            DEF_MOTORS        = 4;
	localparam int            DEF_SAMPLE_PERIOD = 1;
	localparam logic [E_W-1:0] DEF_MAX_ENERGY   = 48'd60000000000;

	localparam logic [LIM_W-1:0] LIMIT_RESET = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_POWER   = 3'd0,
		REG_HIGH_LEVEL  = 3'd1,
		REG_MID_LEVEL   = 3'd2,
		REG_LOW_LEVEL   = 3'd3,
		REG_LIMIT_HIGH  = 3'd4,
		REG_LIMIT_MID   = 3'd5,
		REG_LIMIT_LOW   = 3'd6,
		REG_LIMIT_EMPTY = 3'd7
	} reg_idx_t;

	localparam logic [1:0] ST_PADDING = 2'd0;
	localparam logic [1:0] ST_PASS    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [1:0] LV_HIGH  = 2'd0;
	localparam logic [1:0] LV_MID   = 2'd1;
	localparam logic [1:0] LV_LOW   = 2'd2;
	localparam logic [1:0] LV_EMPTY = 2'd3;

	typedef struct packed {
		logic                    kind;
		logic [15:0]             meas_current;
		logic [15:0]             meas_voltage;
		logic [LVL_W-1:0]        referee_buffer;
		logic signed [CMD_W-1:0] cmd0;
		logic signed [CMD_W-1:0] cmd1;
		logic signed [CMD_W-1:0] cmd2;
		logic signed [CMD_W-1:0] cmd3;
	} in_t;

	typedef struct packed {
		logic [1:0]              pool_status;
		logic [1:0]              pool_level;
		logic signed [CMD_W-1:0] out0;
		logic signed [CMD_W-1:0] out1;
		logic signed [CMD_W-1:0] out2;
		logic signed [CMD_W-1:0] out3;
	} out_t;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_M_MUL   = 9'b000000010,
		S_M_SCALE = 9'b000000100,
		S_M_UPD   = 9'b000001000,
		S_C_SUM   = 9'b000010000,
		S_C_MUL   = 9'b000100000,
		S_C_DIV   = 9'b001000000,
		S_C_STORE = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	typedef struct packed {
		logic              load_in;
		logic              m_mul;
		logic              m_scale;
		logic              m_upd;
		logic              c_sum;
		logic              c_mul;
		logic              c_div;
		logic              c_store;
		logic              out_load;
		logic [MIDX_W-1:0] midx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic kind;
		logic scale;
	} dp_stat_t;

	function automatic logic [1:0] level_of(input logic signed [E_W-1:0] e,
		input logic [LVL_W-1:0] hi, input logic [LVL_W-1:0] mid,
		input logic [LVL_W-1:0] lo);
		logic [E_W-2:0] mag;
		logic [1:0]     lv;
		mag = e[E_W-2:0];
		if (e[E_W-1])
			lv = LV_EMPTY;
		else if (mag >= (E_W-1)'(hi))
			lv = LV_HIGH;
		else if (mag >= (E_W-1)'(mid))
			lv = LV_MID;
		else if (mag >= (E_W-1)'(lo))
			lv = LV_LOW;
		else
			lv = LV_EMPTY;
		return lv;
	endfunction

endpackage

`default_nettype wire

// File: rtl/pbcl_ctrl.sv
// ----------------------------------------------------------------------------
// pbcl_ctrl
// Sequencer: steps the datapath through a measurement or a command item.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcl_ctrl import pbcl_pkg::*; #(
	parameter int MOTORS = DEF_MOTORS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output ctrl_cmd_t      cmd,
	input  wire dp_stat_t  stat
);

	localparam int NUSED = (MOTORS < NCMD) ? MOTORS : NCMD;
	localparam logic [MIDX_W-1:0] LAST_IDX = MIDX_W'(NUSED - 1);

	state_t              state_q, state_d;
	logic [MIDX_W-1:0]   midx_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			// kind of the item waiting at the input picks the first work state
			S_IDLE: begin
				if (in_valid)
					state_d = stat.kind ? S_C_SUM : S_M_MUL;
			end
			S_M_MUL:   state_d = S_M_SCALE;
			S_M_SCALE: state_d = S_M_UPD;
			S_M_UPD:   state_d = S_DONE;
			S_C_SUM:   state_d = S_C_MUL;
			S_C_MUL:   state_d = stat.scale ? S_C_DIV : S_C_STORE;
			S_C_DIV: begin
				if (step_q == STEP_W'(QSTEPS - 1))
					state_d = S_C_STORE;
			end
			S_C_STORE: state_d = (midx_q == LAST_IDX) ? S_DONE : S_C_MUL;
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == S_IDLE) && in_valid;
		cmd.m_mul    = (state_q == S_M_MUL);
		cmd.m_scale  = (state_q == S_M_SCALE);
		cmd.m_upd    = (state_q == S_M_UPD);
		cmd.c_sum    = (state_q == S_C_SUM);
		cmd.c_mul    = (state_q == S_C_MUL);
		cmd.c_div    = (state_q == S_C_DIV);
		cmd.c_store  = (state_q == S_C_STORE);
		cmd.out_load = (state_q == S_DONE) && out_free;
		cmd.midx     = midx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			midx_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_C_SUM)
				midx_q <= '0;
			else if (state_q == S_C_STORE)
				midx_q <= midx_q + 1'b1;
			if (state_q == S_C_MUL)
				step_q <= '0;
			else if (state_q == S_C_DIV)
				step_q <= step_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/pbcl_dp.sv
// ----------------------------------------------------------------------------
// pbcl_dp
// Datapath: config registers, energy integrator, command scaler, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcl_dp import pbcl_pkg::*; #(
	parameter int             MOTORS        = DEF_MOTORS,
	parameter int             SAMPLE_PERIOD = DEF_SAMPLE_PERIOD,
	parameter logic [E_W-1:0] MAX_ENERGY    = DEF_MAX_ENERGY
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire in_t                   in_data,
	output out_t                       out_data,
	input  wire ctrl_cmd_t             cmd,
	output dp_stat_t                   stat
);

	localparam int NUSED = (MOTORS < NCMD) ? MOTORS : NCMD;
	localparam int SP_W  = $clog2(SAMPLE_PERIOD + 1);
	localparam int SC_W  = PWR_W + 2 + SP_W;
	localparam int ACC_W = E_W + 2;
	localparam logic signed [ACC_W-1:0] E_MAX_X = ACC_W'({1'b0, {(E_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] E_MIN_X = -E_MAX_X - 1;

	// configuration registers
	logic [PWR_W-1:0] max_power_q;
	logic [LVL_W-1:0] high_level_q, mid_level_q, low_level_q;
	logic [LIM_W-1:0] limit_high_q, limit_mid_q, limit_low_q, limit_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_power_q   <= '0;
			high_level_q  <= '0;
			mid_level_q   <= '0;
			low_level_q   <= '0;
			limit_high_q  <= LIMIT_RESET;
			limit_mid_q   <= LIMIT_RESET;
			limit_low_q   <= LIMIT_RESET;
			limit_empty_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MAX_POWER:   max_power_q   <= cfg_data[PWR_W-1:0];
				REG_HIGH_LEVEL:  high_level_q  <= cfg_data[LVL_W-1:0];
				REG_MID_LEVEL:   mid_level_q   <= cfg_data[LVL_W-1:0];
				REG_LOW_LEVEL:   low_level_q   <= cfg_data[LVL_W-1:0];
				REG_LIMIT_HIGH:  limit_high_q  <= cfg_data[LIM_W-1:0];
				REG_LIMIT_MID:   limit_mid_q   <= cfg_data[LIM_W-1:0];
				REG_LIMIT_LOW:   limit_low_q   <= cfg_data[LIM_W-1:0];
				REG_LIMIT_EMPTY: limit_empty_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// item and working registers
	in_t                     in_q;
	logic [PWR_W-1:0]        power_q;
	logic                    pad_q;
	logic signed [SC_W-1:0]  scaled_q;
	logic signed [E_W-1:0]   energy_q;
	logic [1:0]              status_q, level_q;
	logic [LIM_W-1:0]        limit_q;
	logic [SUM_W-1:0]        sum_q;
	logic                    scale_q;
	logic [SUM_W-1:0]        rem_q;
	logic [QSTEPS-1:0]       quo_q;
	logic signed [CMD_W-1:0] res_q [NCMD];
	out_t                    out_q;

	logic signed [CMD_W-1:0] cmd_a [NCMD];
	logic [CMD_W-1:0]        mag_a [NCMD];
	logic [SUM_W-1:0]        sum_c;
	logic [1:0]              lvl_c;
	logic [LIM_W-1:0]        lim_c;
	logic signed [PWR_W:0]   margin;
	logic signed [SC_W-1:0]  margin_x;
	logic signed [ACC_W-1:0] acc, sat;
	logic signed [E_W-1:0]   e_cap, e_fin;
	logic                    full;
	logic [PROD_W-1:0]       prod;
	logic [SUM_W:0]          trial;
	logic                    ge;

	assign cmd_a[0] = in_q.cmd0;
	assign cmd_a[1] = in_q.cmd1;
	assign cmd_a[2] = in_q.cmd2;
	assign cmd_a[3] = in_q.cmd3;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NCMD; i++) begin
			mag_a[i] = cmd_a[i][CMD_W-1] ? CMD_W'(-cmd_a[i]) : CMD_W'(cmd_a[i]);
			if (i < NUSED)
				sum_c = sum_c + SUM_W'(mag_a[i]);
		end
		lvl_c = level_of(energy_q, high_level_q, mid_level_q, low_level_q);
		case (lvl_c)
			LV_HIGH: lim_c = limit_high_q;
			LV_MID:  lim_c = limit_mid_q;
			LV_LOW:  lim_c = limit_low_q;
			default: lim_c = limit_empty_q;
		endcase
	end

	// energy update
	always_comb begin
		margin   = $signed({1'b0, max_power_q}) - $signed({1'b0, power_q});
		margin_x = SC_W'(margin);
		acc      = ACC_W'(energy_q) + ACC_W'(scaled_q);
		if (acc > E_MAX_X)
			sat = E_MAX_X;
		else if (acc < E_MIN_X)
			sat = E_MIN_X;
		else
			sat = acc;
		full  = (sat >= $signed(ACC_W'(MAX_ENERGY)));
		e_cap = full ? $signed(MAX_ENERGY) : E_W'(sat);
		if (e_cap > $signed(E_W'(in_q.referee_buffer)))
			e_fin = $signed(E_W'(in_q.referee_buffer));
		else
			e_fin = e_cap;
	end

	// divider step: quotient fits QSTEPS bits since limit < sum
	always_comb begin
		prod  = PROD_W'(limit_q) * PROD_W'(mag_a[cmd.midx]);
		trial = {rem_q, quo_q[QSTEPS-1]};
		ge    = (trial >= {1'b0, sum_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q     <= in_data;
			status_q <= ST_PADDING;
			for (int i = 0; i < NCMD; i++)
				res_q[i] <= '0;
		end
		if (cmd.m_mul)
			power_q <= PWR_W'(in_q.meas_current) * PWR_W'(in_q.meas_voltage);
		if (cmd.m_scale) begin
			scaled_q <= margin_x * SC_W'(SAMPLE_PERIOD);
			pad_q    <= (power_q <= max_power_q);
		end
		if (cmd.m_upd) begin
			status_q <= full ? ST_FULL : (pad_q ? ST_PADDING : ST_PASS);
			level_q  <= level_of(e_fin, high_level_q, mid_level_q, low_level_q);
		end
		if (cmd.c_sum) begin
			sum_q   <= sum_c;
			level_q <= lvl_c;
			limit_q <= lim_c;
			scale_q <= (sum_c != '0) && (sum_c > SUM_W'(lim_c));
		end
		if (cmd.c_mul) begin
			rem_q <= SUM_W'(prod[PROD_W-1:QSTEPS]);
			quo_q <= prod[QSTEPS-1:0];
		end
		if (cmd.c_div) begin
			rem_q <= ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
			quo_q <= {quo_q[QSTEPS-2:0], ge};
		end
		if (cmd.c_store) begin
			if (!scale_q)
				res_q[cmd.midx] <= cmd_a[cmd.midx];
			else if (cmd_a[cmd.midx][CMD_W-1])
				res_q[cmd.midx] <= $signed(CMD_W'(-quo_q));
			else
				res_q[cmd.midx] <= $signed(quo_q);
		end
		if (cmd.out_load) begin
			out_q.pool_status <= status_q;
			out_q.pool_level  <= level_q;
			out_q.out0        <= res_q[0];
			out_q.out1        <= res_q[1];
			out_q.out2        <= res_q[2];
			out_q.out3        <= res_q[3];
		end
	end

	// stored energy is control state: it must read zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			energy_q <= '0;
		else if (cmd.m_upd)
			energy_q <= e_fin;
	end

	assign stat.kind  = in_data.kind;
	assign stat.scale = scale_q;
	assign out_data   = out_q;

endmodule

`default_nettype wire

// File: rtl/power_buffer_current_limiter.sv
// ----------------------------------------------------------------------------
// power_buffer_current_limiter
// Integrates the power margin into a stored energy and scales motor commands
// against a limit chosen by the energy level.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | item
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data      | measurement or command set
//  out     | out_valid, out_ready, out_data   | status, level, limited cmds
//  cfg     | cfg_we, cfg_idx, cfg_data        | one register write, no wait
//
//  A measurement item runs from accept to result through multiply, scale,
//  update, then load of the output register.
//  A command item runs a sum step, then per motor a product, 16 restoring
//  divider steps (one quotient bit per cycle) and a store, then the load;
//  with no scaling the divider steps are skipped.
//  One item is in work at a time; the next is accepted once the current one
//  has moved into the output register, even while that result waits.
//  A stalled output holds the sequencer in its last state.
//  Reset clears the stored energy and the sequencer and resets the configuration.
//
`default_nettype none

module power_buffer_current_limiter import pbcl_pkg::*; #(
	parameter int             MOTORS        = DEF_MOTORS,
	parameter int             SAMPLE_PERIOD = DEF_SAMPLE_PERIOD,
	parameter logic [E_W-1:0] MAX_ENERGY    = DEF_MAX_ENERGY
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequence the item
	pbcl_ctrl #(
		.MOTORS(MOTORS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// hold config, energy and results
	pbcl_dp #(
		.MOTORS        (MOTORS),
		.SAMPLE_PERIOD (SAMPLE_PERIOD),
		.MAX_ENERGY    (MAX_ENERGY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);

`include "power_buffer_current_limiter_assert.svh"

	// an accepted item blocks the input until its result is loaded
	`PBCL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input not held busy")
	// status never takes the unused code
	`PBCL_ASSERT_IMP(a_status_code, out_valid, out_data.pool_status != 2'd3, "bad pool status")
	// a nonzero status marks a measurement result, whose commands are zero
	`PBCL_ASSERT_IMP(a_meas_zero, out_valid && (out_data.pool_status != ST_PADDING), (out_data.out0 == '0) && (out_data.out1 == '0) && (out_data.out2 == '0) && (out_data.out3 == '0), "measurement result carries commands")

endmodule

`default_nettype wire
